[rtl/qmd_pkg.sv]
// Shared types, mode and operation codes, and elaboration-time constant functions
// for the QAM mapper and demapper. It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qmd_pkg;

  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned FRAC_BITS    = 13;
  localparam int unsigned BITS_WIDTH   = 6;

  typedef enum logic [1:0] {
    MODE_QPSK  = 2'd0,
    MODE_QAM16 = 2'd1,
    MODE_QAM64 = 2'd2
  } mode_t;

  localparam logic OP_MAP   = 1'b0;
  localparam logic OP_DEMAP = 1'b1;

  typedef struct packed {
    logic                           op;
    logic [BITS_WIDTH-1:0]          bits_in;
    logic signed [SAMPLE_WIDTH-1:0] sample_i;
    logic signed [SAMPLE_WIDTH-1:0] sample_q;
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] point_i;
    logic signed [SAMPLE_WIDTH-1:0] point_q;
    logic [BITS_WIDTH-1:0]          bits_out;
  } res_t;

  // Rounded value of k * 2^FRAC_BITS / sqrt(m), saturated to the largest positive sample.
  function automatic logic [63:0] level_code(input int unsigned k, input int unsigned m);
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [127:0] d;
    logic [63:0]  v;
    logic [63:0]  c;
    logic [63:0]  vmax;
    rhs  = 128'(k * k) << (2 * FRAC_BITS + 2);
    v    = '0;
    vmax = (64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1;
    for (int b = FRAC_BITS; b >= 0; b--) begin
      c   = v | (64'd1 << b);
      d   = 128'((c << 1) - 64'd1);
      lhs = d * d * 128'(m);
      if (lhs <= rhs) begin
        v = c;
      end
    end
    return (v > vmax) ? vmax : v;
  endfunction

  // Largest integer v with v / 2^FRAC_BITS not above t / sqrt(m).
  function automatic logic [63:0] thr_code(input int unsigned t, input int unsigned m);
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [63:0]  v;
    logic [63:0]  c;
    rhs = 128'(t * t) << (2 * FRAC_BITS);
    v   = '0;
    for (int b = FRAC_BITS + 1; b >= 0; b--) begin
      c   = v | (64'd1 << b);
      lhs = 128'(c) * 128'(c) * 128'(m);
      if (lhs <= rhs) begin
        v = c;
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/qam_mapper_demapper.sv]
// Top level of the QAM mapper and hard-decision demapper: request and result
// registers, mode register and flow control. Depends on qmd_pkg and qmd_core.
`timescale 1ns / 1ps
`default_nettype none

// Takes one request per clock while in_stall is low; each request passes through an input
// register, then the mapping or decision logic into the result register.
// A new request is taken while a finished result waits to be collected; in_stall rises
// only when both registers are full and out_stall is high. The mode register selects
// QPSK, 16-QAM or 64-QAM and resets to QPSK; the unused code returns an all-zero
// result. The constellation levels and decision thresholds are constants worked out
// at elaboration. Write the mode only while no request is in flight.
module qam_mapper_demapper (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic [1:0]    cfg_wdata,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire qmd_pkg::req_t in_req,
  output logic               out_valid,
  input  wire logic          out_stall,
  output qmd_pkg::res_t      out_res
);

  qmd_pkg::mode_t mode_r;
  qmd_pkg::mode_t mode_nxt;
  logic           s1_valid_r;
  logic           s1_valid_nxt;
  qmd_pkg::req_t  s1_req_r;
  qmd_pkg::req_t  s1_req_nxt;
  logic           out_valid_r;
  logic           out_valid_nxt;
  qmd_pkg::res_t  out_res_r;
  qmd_pkg::res_t  out_res_nxt;
  qmd_pkg::res_t  core_res;
  logic           adv_out;
  logic           in_acc;

  qmd_core u_core (
    .mode (mode_r),
    .req  (s1_req_r),
    .res  (core_res)
  );

  assign adv_out  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv_out;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    mode_nxt      = cfg_wr_en ? qmd_pkg::mode_t'(cfg_wdata) : mode_r;
    s1_valid_nxt  = in_acc ? 1'b1 : (adv_out ? 1'b0 : s1_valid_r);
    s1_req_nxt    = in_acc ? in_req : s1_req_r;
    out_valid_nxt = adv_out ? s1_valid_r : out_valid_r;
    out_res_nxt   = (adv_out && s1_valid_r) ? core_res : out_res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= qmd_pkg::MODE_QPSK;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    s1_req_r  <= s1_req_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // A held request moves on to the result register whenever that register can take it.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && adv_out |=> out_valid_r)
    else $error("request in the input register was not moved to the result register");

  // A mapped point and decided bits never appear in the same result.
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ((out_res_r.point_i != '0) || (out_res_r.point_q != '0))
      |-> (out_res_r.bits_out == '0))
    else $error("result carries both a point and decided bits");

  // The mode changes only on a configuration write.
  a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_wr_en |=> $stable(mode_r))
    else $error("mode changed without a configuration write");

endmodule

`default_nettype wire

[rtl/qmd_core.sv]
// Combinational mapper and hard-decision demapper for one request.
// Depends on qmd_pkg for the request and result types, codes and constants.
`timescale 1ns / 1ps
`default_nettype none

module qmd_core (
  input  wire qmd_pkg::mode_t mode,
  input  wire qmd_pkg::req_t  req,
  output qmd_pkg::res_t       res
);

  localparam int unsigned SW = qmd_pkg::SAMPLE_WIDTH;
  localparam int unsigned CW = (qmd_pkg::SAMPLE_WIDTH > qmd_pkg::FRAC_BITS + 2) ?
                               qmd_pkg::SAMPLE_WIDTH : qmd_pkg::FRAC_BITS + 2;

  localparam logic [63:0] L1_2_W  = qmd_pkg::level_code(1, 2);
  localparam logic [63:0] L1_10_W = qmd_pkg::level_code(1, 10);
  localparam logic [63:0] L3_10_W = qmd_pkg::level_code(3, 10);
  localparam logic [63:0] L1_42_W = qmd_pkg::level_code(1, 42);
  localparam logic [63:0] L3_42_W = qmd_pkg::level_code(3, 42);
  localparam logic [63:0] L5_42_W = qmd_pkg::level_code(5, 42);
  localparam logic [63:0] L7_42_W = qmd_pkg::level_code(7, 42);
  localparam logic [63:0] T2_10_W = qmd_pkg::thr_code(2, 10);
  localparam logic [63:0] T2_42_W = qmd_pkg::thr_code(2, 42);
  localparam logic [63:0] T4_42_W = qmd_pkg::thr_code(4, 42);
  localparam logic [63:0] T6_42_W = qmd_pkg::thr_code(6, 42);

  localparam logic [SW-1:0] L1_2  = L1_2_W[SW-1:0];
  localparam logic [SW-1:0] L1_10 = L1_10_W[SW-1:0];
  localparam logic [SW-1:0] L3_10 = L3_10_W[SW-1:0];
  localparam logic [SW-1:0] L1_42 = L1_42_W[SW-1:0];
  localparam logic [SW-1:0] L3_42 = L3_42_W[SW-1:0];
  localparam logic [SW-1:0] L5_42 = L5_42_W[SW-1:0];
  localparam logic [SW-1:0] L7_42 = L7_42_W[SW-1:0];
  localparam logic [CW-1:0] T2_10 = T2_10_W[CW-1:0];
  localparam logic [CW-1:0] T2_42 = T2_42_W[CW-1:0];
  localparam logic [CW-1:0] T4_42 = T4_42_W[CW-1:0];
  localparam logic [CW-1:0] T6_42 = T6_42_W[CW-1:0];

  // Gray order of the 64-QAM magnitude bits: 00 -> 1, 01 -> 3, 11 -> 5, 10 -> 7.
  function automatic logic [SW-1:0] gray64_level(input logic [1:0] g);
    logic [SW-1:0] lvl;
    case (g)
      2'b00:   lvl = L1_42;
      2'b01:   lvl = L3_42;
      2'b11:   lvl = L5_42;
      default: lvl = L7_42;
    endcase
    return lvl;
  endfunction

  function automatic logic [SW-1:0] apply_sign(input logic neg, input logic [SW-1:0] lvl);
    return neg ? SW'(~lvl + 1'b1) : lvl;
  endfunction

  // Decisions for one axis: sign bit first, then the magnitude bits.
  function automatic logic [2:0] demap_axis(input logic [SW-1:0] r, input qmd_pkg::mode_t md);
    logic          neg;
    logic [SW-1:0] mag_n;
    logic [CW-1:0] mag;
    logic [2:0]    d;
    neg   = r[SW-1];
    mag_n = neg ? SW'(~r + 1'b1) : r;
    mag   = CW'(mag_n);
    unique case (md)
      qmd_pkg::MODE_QPSK:  d = {2'b00, neg | (r == '0)};
      qmd_pkg::MODE_QAM16: d = {1'b0, neg, mag > T2_10};
      qmd_pkg::MODE_QAM64: d = {neg, mag > T4_42, (mag > T2_42) && !(mag > T6_42)};
      default:             d = 3'b000;
    endcase
    return d;
  endfunction

  logic          mode_ok;
  logic          neg_i;
  logic          neg_q;
  logic [SW-1:0] lvl_i;
  logic [SW-1:0] lvl_q;
  logic [2:0]    dm_i;
  logic [2:0]    dm_q;
  logic [qmd_pkg::BITS_WIDTH-1:0] dm_bits;

  assign dm_i = demap_axis(req.sample_i, mode);
  assign dm_q = demap_axis(req.sample_q, mode);

  always_comb begin
    mode_ok = 1'b1;
    neg_i   = 1'b0;
    neg_q   = 1'b0;
    lvl_i   = '0;
    lvl_q   = '0;
    dm_bits = '0;
    unique case (mode)
      qmd_pkg::MODE_QPSK: begin
        neg_i   = req.bits_in[1];
        neg_q   = req.bits_in[0];
        lvl_i   = L1_2;
        lvl_q   = L1_2;
        dm_bits = {4'b0000, dm_i[0], dm_q[0]};
      end
      qmd_pkg::MODE_QAM16: begin
        neg_i   = req.bits_in[3];
        neg_q   = req.bits_in[1];
        lvl_i   = req.bits_in[2] ? L3_10 : L1_10;
        lvl_q   = req.bits_in[0] ? L3_10 : L1_10;
        dm_bits = {2'b00, dm_i[1:0], dm_q[1:0]};
      end
      qmd_pkg::MODE_QAM64: begin
        neg_i   = req.bits_in[5];
        neg_q   = req.bits_in[2];
        lvl_i   = gray64_level(req.bits_in[4:3]);
        lvl_q   = gray64_level(req.bits_in[1:0]);
        dm_bits = {dm_i, dm_q};
      end
      default: begin
        mode_ok = 1'b0;
      end
    endcase

    res = '0;
    if (mode_ok) begin
      if (req.op == qmd_pkg::OP_MAP) begin
        res.point_i = apply_sign(neg_i, lvl_i);
        res.point_q = apply_sign(neg_q, lvl_q);
      end else begin
        res.bits_out = dm_bits;
      end
    end
  end

endmodule

`default_nettype wire
